/* rtl/cjm_pkg.sv */
// Shared types, constants and helpers for the card job machine.
// Used by every module under rtl except cjm_ram; depends on nothing else.

package cjm_pkg;

	localparam int MEM_WORDS_DEF   = 100;
	localparam int CARD_WORDS_DEF  = 10;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int WORD_W = 32;
	localparam int ADDR_W = 7;
	localparam int PD_WORDS = 10;

	localparam logic [ADDR_W-1:0] IC_MAX = 7'd127;
	localparam logic [3:0] PD_LAST = 4'(PD_WORDS - 1);

	localparam logic [WORD_W-1:0] STARS = 32'h2A2A2A2A;

	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_B = 8'h42;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_H = 8'h48;
	localparam logic [7:0] CH_L = 8'h4C;
	localparam logic [7:0] CH_P = 8'h50;
	localparam logic [7:0] CH_R = 8'h52;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_T = 8'h54;

	// Input mode codes.
	localparam logic [2:0] MODE_JOB   = 3'd0;
	localparam logic [2:0] MODE_PROG  = 3'd1;
	localparam logic [2:0] MODE_BEGIN = 3'd2;
	localparam logic [2:0] MODE_DATA  = 3'd3;
	localparam logic [2:0] MODE_STEP  = 3'd4;

	// Result kind codes.
	localparam logic [2:0] KIND_ACK         = 3'd0;
	localparam logic [2:0] KIND_WORD        = 3'd1;
	localparam logic [2:0] KIND_AWAIT       = 3'd2;
	localparam logic [2:0] KIND_HALT        = 3'd3;
	localparam logic [2:0] KIND_BAD_OPERAND = 3'd4;
	localparam logic [2:0] KIND_BAD_OPCODE  = 3'd5;
	localparam logic [2:0] KIND_IGNORED     = 3'd6;

	typedef enum logic [2:0] {
		CMD_JOB,
		CMD_PROG,
		CMD_BEGIN,
		CMD_DATA,
		CMD_STEP,
		CMD_IGNORE
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [WORD_W-1:0]  word;
		logic               last;
	} q_item_t;

	typedef enum logic [1:0] {
		PH_LOAD,
		PH_EXEC,
		PH_WAIT,
		PH_STOP
	} phase_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DECODE,
		BK_OPER,
		BK_PD_RD,
		BK_PD_OUT
	} bk_state_t;

	function automatic logic is_digit(input logic [7:0] ch);
		return (ch >= CH_0) && (ch <= CH_9);
	endfunction

	function automatic cmd_t classify(input logic [2:0] mode);
		cmd_t c;
		case (mode)
			MODE_JOB:   c = CMD_JOB;
			MODE_PROG:  c = CMD_PROG;
			MODE_BEGIN: c = CMD_BEGIN;
			MODE_DATA:  c = CMD_DATA;
			MODE_STEP:  c = CMD_STEP;
			default:    c = CMD_IGNORE;
		endcase
		return c;
	endfunction

endpackage

/* rtl/cjm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.

module cjm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 100,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/cjm_front.sv */
// Front end: takes input words, classifies the mode into a command and
// holds it in one register stage. Depends on cjm_pkg.

module cjm_front import cjm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [2:0]        mode,
	input  logic [WORD_W-1:0] card_word,
	input  logic              last_of_card,
	output logic              q_valid,
	input  logic              q_ready,
	output q_item_t           q_item
);

	logic    item_v_s1;
	q_item_t item_s1;

	assign item_ready = !item_v_s1 || q_ready;
	assign q_valid    = item_v_s1;
	assign q_item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
		end else if (item_ready) begin
			item_v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1.cmd  <= classify(mode);
			item_s1.word <= card_word;
			item_s1.last <= last_of_card;
		end
	end

endmodule

/* rtl/cjm_fifo.sv */
// Short command queue between the front end and the execution back end.
// Depends on cjm_pkg for the queued word type.

module cjm_fifo import cjm_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	output logic    push_ready,
	input  q_item_t push_item,
	output logic    pop_valid,
	input  logic    pop_ready,
	output q_item_t pop_item
);

	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	q_item_t        entry_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (cnt_q != CNT_FULL);
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* rtl/cjm_back.sv */
// Back end: executes queued commands against main memory and the machine
// registers, and drives the result register. Depends on cjm_pkg, cjm_ram.

module cjm_back import cjm_pkg::*; #(
	parameter int MEM_WORDS  = MEM_WORDS_DEF,
	parameter int CARD_WORDS = CARD_WORDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  q_item_t           q_item,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [2:0]        kind,
	output logic [WORD_W-1:0] out_word,
	output logic              last
);

	localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam int CNT_W = $clog2(CARD_WORDS + 1);
	localparam logic [ADDR_W-1:0] MEM_LIM = ADDR_W'(MEM_WORDS);
	localparam logic [ADDR_W-1:0] CARD_SPAN = ADDR_W'(CARD_WORDS);
	localparam logic [CNT_W-1:0] CARD_MAX = CNT_W'(CARD_WORDS);

	bk_state_t state_q, state_d;
	phase_t    phase_q, phase_d;

	logic [WORD_W-1:0]    gr_q, gr_d;
	logic [ADDR_W-1:0]    ic_q, ic_d;
	logic                 flag_q, flag_d;
	logic [3:0]           lp_tens_q, lp_tens_d;
	logic [3:0]           lp_ones_q, lp_ones_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [ADDR_W-1:0]    rt_q, rt_d;
	logic [MEM_WORDS-1:0] valid_q, valid_d;
	logic                 is_cr_q, is_cr_d;
	logic [ADDR_W-1:0]    pd_addr_q, pd_addr_d;
	logic [3:0]           pd_i_q, pd_i_d;
	logic                 rd_star_q;
	logic                 out_v_q, out_v_d;
	logic [2:0]           kind_q, kind_d;
	logic [WORD_W-1:0]    word_q, word_d;
	logic                 last_q, last_d;

	logic                 can_emit;
	logic                 we_c, re_c, ram_we;
	logic [ADDR_W-1:0]    waddr_c, raddr_c;
	logic [WORD_W-1:0]    wdata_c;
	logic [WORD_W-1:0]    ram_rdata, rdata_eff;
	logic [ADDR_W-1:0]    lp_val;
	logic [CNT_W-1:0]     cnt_inc;
	logic [ADDR_W-1:0]    pad_lo, pad_hi;
	logic [7:0]           c0, c1, c2, c3;
	logic [ADDR_W-1:0]    op;

	assign can_emit = !out_v_q || result_ready;

	// Load pointer is kept as tens and ones so that rounding up needs no divide.
	assign lp_val = {lp_tens_q, 3'b000} + {2'b00, lp_tens_q, 1'b0} + {3'b000, lp_ones_q};

	assign cnt_inc = (cnt_q < CARD_MAX) ? cnt_q + 1'b1 : cnt_q;
	assign pad_lo  = rt_q + ADDR_W'(cnt_inc);
	assign pad_hi  = rt_q + CARD_SPAN;

	assign rdata_eff = rd_star_q ? STARS : ram_rdata;
	assign c0 = rdata_eff[31:24];
	assign c1 = rdata_eff[23:16];
	assign c2 = rdata_eff[15:8];
	assign c3 = rdata_eff[7:0];
	assign op = {c2[3:0], 3'b000} + {2'b00, c2[3:0], 1'b0} + {3'b000, c3[3:0]};

	assign ram_we = we_c && (waddr_c < MEM_LIM);

	cjm_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MEM_WORDS)
	) u_mem (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr_c[AW-1:0]),
		.wdata(wdata_c),
		.re   (re_c),
		.raddr(raddr_c[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		gr_d      = gr_q;
		ic_d      = ic_q;
		flag_d    = flag_q;
		lp_tens_d = lp_tens_q;
		lp_ones_d = lp_ones_q;
		cnt_d     = cnt_q;
		rt_d      = rt_q;
		valid_d   = valid_q;
		is_cr_d   = is_cr_q;
		pd_addr_d = pd_addr_q;
		pd_i_d    = pd_i_q;
		out_v_d   = out_v_q && !result_ready;
		kind_d    = kind_q;
		word_d    = word_q;
		last_d    = last_q;
		q_ready   = 1'b0;
		we_c      = 1'b0;
		waddr_c   = lp_val;
		wdata_c   = q_item.word;
		re_c      = 1'b0;
		raddr_c   = ic_q;

		case (state_q)
			BK_IDLE: begin
				if (q_valid && q_item.cmd == CMD_STEP && phase_q == PH_EXEC) begin
					q_ready = 1'b1;
					re_c    = 1'b1;
					raddr_c = ic_q;
					ic_d    = (ic_q == IC_MAX) ? ic_q : ic_q + 1'b1;
					state_d = BK_DECODE;
				end else if (q_valid && can_emit) begin
					q_ready = 1'b1;
					out_v_d = 1'b1;
					kind_d  = KIND_ACK;
					word_d  = '0;
					last_d  = 1'b1;
					case (q_item.cmd)
						CMD_JOB: begin
							valid_d   = '0;
							gr_d      = STARS;
							ic_d      = '0;
							flag_d    = 1'b0;
							lp_tens_d = '0;
							lp_ones_d = '0;
							cnt_d     = '0;
							rt_d      = '0;
							phase_d   = PH_LOAD;
						end
						CMD_PROG: begin
							if (phase_q != PH_LOAD) begin
								kind_d = KIND_IGNORED;
							end else begin
								if (cnt_q < CARD_MAX && lp_val < MEM_LIM) begin
									we_c    = 1'b1;
									waddr_c = lp_val;
									if (lp_ones_q == 4'd9) begin
										lp_ones_d = '0;
										lp_tens_d = lp_tens_q + 1'b1;
									end else begin
										lp_ones_d = lp_ones_q + 1'b1;
									end
								end
								cnt_d = cnt_inc;
								if (q_item.last) begin
									if (lp_ones_d != '0) begin
										lp_tens_d = lp_tens_d + 1'b1;
										lp_ones_d = '0;
									end
									cnt_d = '0;
								end
							end
						end
						CMD_BEGIN: begin
							if (phase_q != PH_LOAD) begin
								kind_d = KIND_IGNORED;
							end else begin
								ic_d    = '0;
								cnt_d   = '0;
								phase_d = PH_EXEC;
							end
						end
						CMD_DATA: begin
							if (phase_q != PH_WAIT) begin
								kind_d = KIND_IGNORED;
							end else begin
								if (cnt_q < CARD_MAX) begin
									we_c    = 1'b1;
									waddr_c = rt_q + ADDR_W'(cnt_q);
								end
								cnt_d = cnt_inc;
								if (q_item.last) begin
									// Padding with '*' is the same as marking the rest of
									// the card area as never written.
									for (int e = 0; e < MEM_WORDS; e++) begin
										if (ADDR_W'(e) >= pad_lo && ADDR_W'(e) < pad_hi) begin
											valid_d[e] = 1'b0;
										end
									end
									cnt_d   = '0;
									phase_d = PH_EXEC;
								end
							end
						end
						default: begin
							kind_d = KIND_IGNORED;
						end
					endcase
				end
			end

			BK_DECODE: begin
				// The fetched word stays on the RAM output until the next read.
				if (can_emit) begin
					state_d = BK_IDLE;
					word_d  = '0;
					last_d  = 1'b1;
					kind_d  = KIND_ACK;
					out_v_d = 1'b1;
					if (c0 == CH_H) begin
						phase_d = PH_STOP;
						kind_d  = KIND_HALT;
					end else if (!is_digit(c2) || !is_digit(c3)) begin
						phase_d = PH_STOP;
						kind_d  = KIND_BAD_OPERAND;
					end else if (c0 == CH_G && c1 == CH_D) begin
						rt_d    = op;
						cnt_d   = '0;
						phase_d = PH_WAIT;
						kind_d  = KIND_AWAIT;
					end else if (c0 == CH_P && c1 == CH_D) begin
						out_v_d   = out_v_q && !result_ready;
						kind_d    = kind_q;
						word_d    = word_q;
						last_d    = last_q;
						pd_addr_d = op;
						pd_i_d    = '0;
						state_d   = BK_PD_RD;
					end else if ((c0 == CH_L || c0 == CH_C) && c1 == CH_R) begin
						out_v_d = out_v_q && !result_ready;
						kind_d  = kind_q;
						word_d  = word_q;
						last_d  = last_q;
						re_c    = 1'b1;
						raddr_c = op;
						is_cr_d = (c0 == CH_C);
						state_d = BK_OPER;
					end else if (c0 == CH_S && c1 == CH_R) begin
						we_c    = 1'b1;
						waddr_c = op;
						wdata_c = gr_q;
					end else if (c0 == CH_B && c1 == CH_T) begin
						if (flag_q) begin
							ic_d = op;
						end
					end else begin
						phase_d = PH_STOP;
						kind_d  = KIND_BAD_OPCODE;
					end
				end
			end

			BK_OPER: begin
				if (can_emit) begin
					if (is_cr_q) begin
						flag_d = (gr_q == rdata_eff);
					end else begin
						gr_d = rdata_eff;
					end
					out_v_d = 1'b1;
					kind_d  = KIND_ACK;
					word_d  = '0;
					last_d  = 1'b1;
					state_d = BK_IDLE;
				end
			end

			BK_PD_RD: begin
				re_c    = 1'b1;
				raddr_c = pd_addr_q + ADDR_W'(pd_i_q);
				state_d = BK_PD_OUT;
			end

			BK_PD_OUT: begin
				if (can_emit) begin
					out_v_d = 1'b1;
					kind_d  = KIND_WORD;
					word_d  = rdata_eff;
					last_d  = (pd_i_q == PD_LAST);
					if (pd_i_q == PD_LAST) begin
						state_d = BK_IDLE;
					end else begin
						pd_i_d  = pd_i_q + 1'b1;
						state_d = BK_PD_RD;
					end
				end
			end

			default: begin
				state_d = BK_IDLE;
			end
		endcase

		if (ram_we) begin
			valid_d[waddr_c[AW-1:0]] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			phase_q   <= PH_LOAD;
			gr_q      <= STARS;
			ic_q      <= '0;
			flag_q    <= 1'b0;
			lp_tens_q <= '0;
			lp_ones_q <= '0;
			cnt_q     <= '0;
			rt_q      <= '0;
			valid_q   <= '0;
			is_cr_q   <= 1'b0;
			pd_addr_q <= '0;
			pd_i_q    <= '0;
			rd_star_q <= 1'b1;
			out_v_q   <= 1'b0;
			kind_q    <= KIND_ACK;
			word_q    <= '0;
			last_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			phase_q   <= phase_d;
			gr_q      <= gr_d;
			ic_q      <= ic_d;
			flag_q    <= flag_d;
			lp_tens_q <= lp_tens_d;
			lp_ones_q <= lp_ones_d;
			cnt_q     <= cnt_d;
			rt_q      <= rt_d;
			valid_q   <= valid_d;
			is_cr_q   <= is_cr_d;
			pd_addr_q <= pd_addr_d;
			pd_i_q    <= pd_i_d;
			out_v_q   <= out_v_d;
			kind_q    <= kind_d;
			word_q    <= word_d;
			last_q    <= last_d;
			if (re_c) begin
				// Words past the end of memory and words never written read as "****".
				rd_star_q <= (raddr_c < MEM_LIM) ? !valid_q[raddr_c[AW-1:0]] : 1'b1;
			end
		end
	end

	assign result_valid = out_v_q;
	assign kind         = kind_q;
	assign out_word     = word_q;
	assign last         = last_q;

endmodule

/* rtl/card_job_machine_cpu.sv */
// Card job machine: front stage, command queue and execution back end.
// Each word passes the front stage register and the command queue; the back end answers
// card, begin, job start and ignored words from idle, a step goes through decode, LR and CR
// add an operand read, and each PD word needs its own read and output state. The back end
// takes no new command until its state machine is back in idle; it has one RAM port.
// Reset clears all control state; memory reads as "****" through per-word valid bits.
// Depends on cjm_pkg, cjm_front, cjm_fifo, cjm_back, cjm_ram.

module card_job_machine_cpu import cjm_pkg::*; #(
	parameter int MEM_WORDS   = MEM_WORDS_DEF,
	parameter int CARD_WORDS  = CARD_WORDS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [2:0]        mode,
	input  logic [WORD_W-1:0] card_word,
	input  logic              last_of_card,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [2:0]        kind,
	output logic [WORD_W-1:0] out_word,
	output logic              last
);

	logic    fr_valid, fr_ready;
	q_item_t fr_item;
	logic    bk_valid, bk_ready;
	q_item_t bk_item;

	cjm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.mode        (mode),
		.card_word   (card_word),
		.last_of_card(last_of_card),
		.q_valid     (fr_valid),
		.q_ready     (fr_ready),
		.q_item      (fr_item)
	);

	cjm_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fr_valid),
		.push_ready(fr_ready),
		.push_item (fr_item),
		.pop_valid (bk_valid),
		.pop_ready (bk_ready),
		.pop_item  (bk_item)
	);

	cjm_back #(
		.MEM_WORDS (MEM_WORDS),
		.CARD_WORDS(CARD_WORDS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (bk_valid),
		.q_ready     (bk_ready),
		.q_item      (bk_item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.kind        (kind),
		.out_word    (out_word),
		.last        (last)
	);

endmodule

/* tb/tb_card_job_machine_cpu.sv */
`timescale 1ns / 100ps
// Self-checking testbench for card_job_machine_cpu: directed jobs, then random card decks.
// An internal machine predictor queues the expected words; depends on cjm_pkg and the RTL.

module tb_card_job_machine_cpu;
	import cjm_pkg::*;

	localparam logic [2:0] MODE_RSVD5 = 3'd5;
	localparam logic [2:0] MODE_RSVD6 = 3'd6;
	localparam logic [2:0] MODE_RSVD7 = 3'd7;
	localparam int ROW = 10;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [2:0]        kind;
		logic [WORD_W-1:0] word;
		logic              tail;
	} result_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              item_valid;
	logic              item_ready;
	logic [2:0]        mode;
	logic [WORD_W-1:0] card_word;
	logic              last_of_card;
	logic              result_valid;
	logic              result_ready;
	logic [2:0]        kind;
	logic [WORD_W-1:0] out_word;
	logic              last;

	// Predicted machine state.
	logic [WORD_W-1:0] mem_image [MEM_WORDS_DEF];
	logic [WORD_W-1:0] acc_reg;
	int unsigned       icount;
	logic              cmp_flag;
	int unsigned       load_ptr;
	int unsigned       card_fill;
	int unsigned       data_base;
	phase_t            mach_phase;

	result_t     expected_results[$];
	int unsigned mismatch_count = 0;
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	bit          sender_bursty = 1'b0;
	int unsigned ready_chance = 100;
	int unsigned hold_request = 0;
	int unsigned hold_left = 0;
	int unsigned last_load_addr = 0;

	card_job_machine_cpu DUT (
		.clk, .arst_n, .item_valid, .item_ready, .mode, .card_word, .last_of_card,
		.result_valid, .result_ready, .kind, .out_word, .last
	);

	always #10 clk = ~clk;

	function automatic logic [WORD_W-1:0] mem_peek(input int unsigned a);
		return (a < MEM_WORDS_DEF) ? mem_image[a] : STARS;
	endfunction

	function automatic void mem_poke(input int unsigned a, input logic [WORD_W-1:0] v);
		if (a < MEM_WORDS_DEF)
			mem_image[a] = v;
	endfunction

	function automatic void push_result(input logic [2:0] k, input logic [WORD_W-1:0] w,
			input logic t);
		result_t r;
		r.kind = k;
		r.word = w;
		r.tail = t;
		expected_results.push_back(r);
	endfunction

	function automatic void machine_clear();
		for (int i = 0; i < MEM_WORDS_DEF; i++)
			mem_image[i] = STARS;
		acc_reg = STARS;
		icount = 0;
		cmp_flag = 1'b0;
		load_ptr = 0;
		card_fill = 0;
		data_base = 0;
	endfunction

	// Applies one accepted word to the predicted machine and queues its results.
	function automatic void machine_predict(input logic [2:0] m, input logic [WORD_W-1:0] w,
			input logic lw);
		logic [WORD_W-1:0] ir;
		logic [7:0]        c0, c1, c2, c3;
		int unsigned       opnd;
		case (m)
			MODE_JOB: begin
				machine_clear();
				mach_phase = PH_LOAD;
				push_result(KIND_ACK, '0, 1'b1);
			end
			MODE_PROG: begin
				if (mach_phase != PH_LOAD) begin
					push_result(KIND_IGNORED, '0, 1'b1);
				end else begin
					if (card_fill < CARD_WORDS_DEF && load_ptr < MEM_WORDS_DEF) begin
						mem_poke(load_ptr, w);
						load_ptr++;
					end
					if (card_fill < CARD_WORDS_DEF)
						card_fill++;
					if (lw) begin
						if (load_ptr % ROW != 0)
							load_ptr = (load_ptr / ROW + 1) * ROW;
						card_fill = 0;
					end
					push_result(KIND_ACK, '0, 1'b1);
				end
			end
			MODE_BEGIN: begin
				if (mach_phase != PH_LOAD) begin
					push_result(KIND_IGNORED, '0, 1'b1);
				end else begin
					icount = 0;
					card_fill = 0;
					mach_phase = PH_EXEC;
					push_result(KIND_ACK, '0, 1'b1);
				end
			end
			MODE_DATA: begin
				if (mach_phase != PH_WAIT) begin
					push_result(KIND_IGNORED, '0, 1'b1);
				end else begin
					if (card_fill < CARD_WORDS_DEF) begin
						mem_poke(data_base + card_fill, w);
						card_fill++;
					end
					if (lw) begin
						for (int i = card_fill; i < CARD_WORDS_DEF; i++)
							mem_poke(data_base + i, STARS);
						card_fill = 0;
						mach_phase = PH_EXEC;
					end
					push_result(KIND_ACK, '0, 1'b1);
				end
			end
			MODE_STEP: begin
				if (mach_phase != PH_EXEC) begin
					push_result(KIND_IGNORED, '0, 1'b1);
				end else begin
					ir = mem_peek(icount);
					{c0, c1, c2, c3} = ir;
					if (icount < IC_MAX)
						icount++;
					// Halt is decided on the first character alone, before the operand check.
					if (c0 == CH_H) begin
						mach_phase = PH_STOP;
						push_result(KIND_HALT, '0, 1'b1);
					end else if (c2 < CH_0 || c2 > CH_9 || c3 < CH_0 || c3 > CH_9) begin
						mach_phase = PH_STOP;
						push_result(KIND_BAD_OPERAND, '0, 1'b1);
					end else begin
						opnd = (c2 - CH_0) * 10 + (c3 - CH_0);
						if (c0 == CH_G && c1 == CH_D) begin
							data_base = opnd;
							card_fill = 0;
							mach_phase = PH_WAIT;
							push_result(KIND_AWAIT, '0, 1'b1);
						end else if (c0 == CH_P && c1 == CH_D) begin
							for (int i = 0; i < PD_WORDS; i++)
								push_result(KIND_WORD, mem_peek(opnd + i), i == PD_WORDS - 1);
						end else if (c0 == CH_L && c1 == CH_R) begin
							acc_reg = mem_peek(opnd);
							push_result(KIND_ACK, '0, 1'b1);
						end else if (c0 == CH_S && c1 == CH_R) begin
							mem_poke(opnd, acc_reg);
							push_result(KIND_ACK, '0, 1'b1);
						end else if (c0 == CH_C && c1 == CH_R) begin
							cmp_flag = (acc_reg == mem_peek(opnd));
							push_result(KIND_ACK, '0, 1'b1);
						end else if (c0 == CH_B && c1 == CH_T) begin
							if (cmp_flag)
								icount = opnd;
							push_result(KIND_ACK, '0, 1'b1);
						end else begin
							mach_phase = PH_STOP;
							push_result(KIND_BAD_OPCODE, '0, 1'b1);
						end
					end
				end
			end
			default: begin
				push_result(KIND_IGNORED, '0, 1'b1);
			end
		endcase
	endfunction

	function automatic logic [15:0] two_digits(input int unsigned n);
		return {8'(CH_0 + n / 10), 8'(CH_0 + n % 10)};
	endfunction

	// Mostly well-formed instructions, with halts, broken operands, odd opcodes and noise.
	function automatic logic [WORD_W-1:0] random_instruction(input int unsigned span);
		int unsigned pick, addr;
		logic [7:0]  bad;
		pick = $urandom_range(0, 99);
		addr = ($urandom_range(0, 5) == 0) ? $urandom_range(90, 99) : $urandom_range(0, 99);
		bad = $urandom_range(0, 1) ? 8'($urandom_range(CH_9 + 1, 255))
			: 8'($urandom_range(0, CH_0 - 1));
		if (pick < 14) begin
			last_load_addr = addr;
			return {CH_L, CH_R, two_digits(addr)};
		end
		if (pick < 26)
			return {CH_S, CH_R, two_digits(addr)};
		if (pick < 38)
			return {CH_C, CH_R, two_digits($urandom_range(0, 1) ? last_load_addr : addr)};
		if (pick < 50)
			return {CH_B, CH_T, two_digits(($urandom_range(0, 7) == 0) ?
				$urandom_range(95, 99) : $urandom_range(0, span))};
		if (pick < 58)
			return {CH_G, CH_D, two_digits(addr)};
		if (pick < 66)
			return {CH_P, CH_D, two_digits(addr)};
		if (pick < 72)
			return {CH_H, 24'($urandom)};
		if (pick < 80)
			return {16'($urandom), 8'($urandom), bad};
		if (pick < 88)
			return {16'($urandom), two_digits(addr)};
		return $urandom;
	endfunction

	// Offers one word and returns at the falling edge after it was taken.
	task automatic send_item(input logic [2:0] m, input logic [WORD_W-1:0] w, input logic lw);
		if (sender_bursty && burst_left == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left > 0)
			burst_left--;
		item_valid <= 1'b1;
		mode <= m;
		card_word <= w;
		last_of_card <= lw;
		do @(posedge clk); while (!item_ready);
		machine_predict(m, w, lw);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			result_ready <= 1'b0;
			hold_left--;
		end else begin
			result_ready <= ($urandom_range(0, 99) < ready_chance);
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected word: kind %0d, out_word %h, last %b", kind, out_word, last);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, actual %0d", want.kind, kind);
					mismatch_count++;
				end
				if (out_word !== want.word) begin
					$error("out_word: expected %h, actual %h", want.word, out_word);
					mismatch_count++;
				end
				if (last !== want.tail) begin
					$error("last: expected %b, actual %b", want.tail, last);
					mismatch_count++;
				end
			end
		end
	end

	task automatic test_directed_program();
		sender_bursty = 1'b0;
		ready_chance = 100;
		// While loading, steps, data words and spare modes do nothing.
		send_item(MODE_STEP, "LR00", 1'b0);
		send_item(MODE_DATA, 32'hFFFF_FFFF, 1'b1);
		send_item(MODE_RSVD5, 32'h0, 1'b1);
		send_item(MODE_RSVD6, 32'h0, 1'b0);
		send_item(MODE_RSVD7, 32'hFFFF_FFFF, 1'b1);
		send_item(MODE_JOB, 32'h0, 1'b0);
		send_item(MODE_PROG, "GD20", 1'b0);
		send_item(MODE_PROG, "LR20", 1'b0);
		send_item(MODE_PROG, "SR99", 1'b0);
		send_item(MODE_PROG, "CR99", 1'b0);
		send_item(MODE_PROG, "BT06", 1'b0);
		send_item(MODE_PROG, "HOLD", 1'b0);
		send_item(MODE_PROG, "PD95", 1'b0);
		send_item(MODE_PROG, "H***", 1'b1);
		send_item(MODE_BEGIN, 32'h0, 1'b0);
		send_item(MODE_STEP, 32'h0, 1'b0);
		send_item(MODE_STEP, 32'h0, 1'b0);
		send_item(MODE_DATA, 32'h0000_0000, 1'b0);
		send_item(MODE_DATA, 32'hFFFF_FFFF, 1'b1);
		repeat (6) send_item(MODE_STEP, 32'hFFFF_FFFF, 1'b1);
		// After the halt only a job start counts.
		send_item(MODE_STEP, 32'h0, 1'b0);
		send_item(MODE_PROG, "LR00", 1'b1);
		send_item(MODE_BEGIN, 32'h0, 1'b0);
		send_item(MODE_DATA, 32'h0, 1'b1);
	endtask

	task automatic test_faults();
		sender_bursty = 1'b1;
		ready_chance = 60;
		send_item(MODE_JOB, 32'h0, 1'b0);
		// The card never ends, so begin comes in the middle of it.
		send_item(MODE_PROG, "XY12", 1'b0);
		send_item(MODE_BEGIN, 32'h0, 1'b0);
		send_item(MODE_STEP, 32'h0, 1'b0);
		send_item(MODE_STEP, 32'h0, 1'b0);
		send_item(MODE_JOB, 32'h0, 1'b0);
		send_item(MODE_PROG, "LRAB", 1'b1);
		send_item(MODE_BEGIN, 32'h0, 1'b0);
		send_item(MODE_STEP, 32'h0, 1'b0);
	endtask

	task automatic test_full_memory();
		sender_bursty = 1'b1;
		ready_chance = 70;
		send_item(MODE_JOB, 32'h0, 1'b0);
		send_item(MODE_PROG, "CR51", 1'b0);
		send_item(MODE_PROG, "BT90", 1'b1);
		for (int k = 1; k < 9; k++)
			send_item(MODE_PROG, $urandom, 1'b1);
		send_item(MODE_PROG, "PD95", 1'b1);
		// The pointer now sits at the top of memory, so this word is lost.
		send_item(MODE_PROG, "LR00", 1'b1);
		send_item(MODE_BEGIN, 32'h0, 1'b0);
		repeat (4) send_item(MODE_STEP, 32'h0, 1'b0);
	endtask

	task automatic test_output_stall();
		sender_bursty = 1'b0;
		ready_chance = 100;
		wait_drained();
		send_item(MODE_JOB, 32'h0, 1'b0);
		for (int k = 0; k < 4; k++)
			send_item(MODE_PROG, {CH_P, CH_D, two_digits(k * ROW)}, k == 3);
		send_item(MODE_BEGIN, 32'h0, 1'b0);
		hold_request = HOLD_CYCLES;
		repeat (5) send_item(MODE_STEP, 32'h0, 1'b0);
		repeat (6) send_item(MODE_STEP, 32'h0, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_jobs(input int unsigned target);
		int unsigned goal, jobs, n_cards, n_words, steps, span;
		bit          cut_card, skip_begin;
		goal = items_sent + target;
		jobs = 0;
		while (items_sent < goal) begin
			if ($urandom_range(0, 3) == 0) begin
				sender_bursty = 1'b0;
				ready_chance = 100;
			end else begin
				sender_bursty = 1'b1;
				ready_chance = $urandom_range(30, 100);
			end
			if ($urandom_range(0, 3) == 0)
				send_item(3'($urandom_range(MODE_PROG, MODE_RSVD7)), $urandom, 1'($urandom));
			send_item(MODE_JOB, $urandom, 1'($urandom));
			n_cards = $urandom_range(1, 3);
			span = n_cards * ROW;
			cut_card = ($urandom_range(0, 9) == 0);
			skip_begin = ($urandom_range(0, 19) == 0);
			for (int k = 0; k < n_cards; k++) begin
				n_words = ($urandom_range(0, 6) == 0) ?
					$urandom_range(CARD_WORDS_DEF + 1, CARD_WORDS_DEF + 3) :
					$urandom_range(1, CARD_WORDS_DEF);
				for (int j = 0; j < n_words; j++)
					send_item(MODE_PROG, random_instruction(span),
						(j == n_words - 1) && !(cut_card && k == n_cards - 1));
			end
			if (!skip_begin)
				send_item(MODE_BEGIN, $urandom, 1'($urandom));
			for (steps = 0; steps < 30 && (mach_phase == PH_EXEC || mach_phase == PH_WAIT);
					steps++) begin
				if (mach_phase == PH_WAIT) begin
					n_words = $urandom_range(1, CARD_WORDS_DEF + 2);
					for (int j = 0; j < n_words; j++) begin
						if ($urandom_range(0, 15) == 0)
							send_item(MODE_STEP, $urandom, 1'($urandom));
						send_item(MODE_DATA, $urandom_range(0, 1) ?
							random_instruction(span) : $urandom, j == n_words - 1);
					end
				end else begin
					send_item(MODE_STEP, $urandom, 1'($urandom));
				end
			end
			if (mach_phase == PH_STOP && $urandom_range(0, 2) == 0)
				send_item(3'($urandom_range(MODE_PROG, MODE_RSVD7)), $urandom, 1'($urandom));
			jobs++;
			if (jobs % 9 == 0)
				wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		mode = MODE_JOB;
		card_word = '0;
		last_of_card = 1'b0;
		result_ready = 1'b0;
		machine_clear();
		mach_phase = PH_LOAD;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_program();
		test_faults();
		test_full_memory();
		test_output_stall();
		// The random decks make up the rest of about 470 words in all.
		test_random_jobs(470 - items_sent);
		sender_bursty = 1'b0;
		ready_chance = 100;
		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("card_job_machine_cpu regression: pass");
		else
			$display("card_job_machine_cpu regression: fail");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("card_job_machine_cpu regression: fail");
		$finish;
	end

endmodule
